// File: rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared widths and parameter defaults for the maximum subarray sum tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  // fixed field widths
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned PEAK_W     = 32;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 264;
  localparam int unsigned OUT_USER_W = 1;

  // parameter defaults
  localparam int unsigned MAX_LEN_DEF     = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PEAK_W-1:0] peak_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [IDX_W-1:0]         idx_t;

endpackage

`default_nettype wire

// File: rtl/max_subarray_sum_tracker.sv
// ----------------------------------------------------------------------------
// max_subarray_sum_tracker
// Kadane tracker over one run of signed samples: best sum and span, best
// prefix, best suffix and run total, reported on the last sample of the run.
// ----------------------------------------------------------------------------
// a run-ending sample passes through the input register, then the output register
// throughput: one sample per cycle while not stalled; the single state update between the
//   input register and the state/result registers sets that figure
// a run-ending sample stalls in the input register only while the previous
//   result still waits in the output register and is not taken
// reset clears the run state and both valid flags; data registers are not reset
`default_nettype none

module max_subarray_sum_tracker
  import mss_pkg::*;
#(
  parameter int unsigned MAX_LEN     = MAX_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // sample[31:0]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                  s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // best_sum[47:0], best_start[64:48], best_end[81:65], prefix_sum[129:82],
  // prefix_end[146:130], suffix_sum[194:147], suffix_start[210:195],
  // run_total[258:211], zero pad[263:259]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // too_long[0]
  output logic [OUT_USER_W-1:0]      m_axis_tuser_o
);

  // input register
  logic                 in_valid_q;
  logic [IN_DATA_W-1:0] sample_q;
  logic                 in_last_q;

  // run state
  sum_t  run_sum_q, run_sum_d;
  pos_t  run_start_q, run_start_d;
  sum_t  best_q, best_d;
  pos_t  best_first_q, best_first_d;
  pos_t  best_past_q, best_past_d;
  peak_t peak_q, peak_d;
  idx_t  peak_idx_q, peak_idx_d;
  sum_t  total_q, total_d;
  sum_t  pre_best_q, pre_best_d;
  pos_t  pre_past_q, pre_past_d;
  sum_t  min_pre_q, min_pre_d;
  idx_t  min_idx_q, min_idx_d;
  pos_t  pos_q, pos_d;
  logic  ovf_q, ovf_d;

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_user_q;

  logic stall, proc;

  // only a run-ending word needs room in the output register
  assign stall = in_valid_q & in_last_q & out_valid_q & ~m_axis_tready_i;
  assign proc  = in_valid_q & ~stall;

  assign s_axis_tready_o = ~stall;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  always_comb begin
    sum_t  x;
    peak_t xp;
    pos_t  i_nxt;
    sum_t  run_b, best_b, tot_b, pre_b, minp_b;
    pos_t  rst_b, bfirst_b, bpast_b, ppast_b;
    peak_t peak_b;
    idx_t  pidx_b, minidx_b;
    sum_t  run_sum2, tot2, bsum;
    pos_t  bs, be;

    xp    = PEAK_W'($signed(sample_q[SAMPLE_BITS-1:0]));
    x     = SUM_W'(xp);
    i_nxt = pos_q + POS_W'(1);

    // first sample of a run seeds the state
    if (pos_q == '0) begin
      run_b    = '0;
      rst_b    = '0;
      best_b   = x;
      bfirst_b = '0;
      bpast_b  = POS_W'(1);
      peak_b   = xp;
      pidx_b   = '0;
      tot_b    = '0;
      pre_b    = x;
      ppast_b  = POS_W'(1);
      minp_b   = '0;
      minidx_b = '0;
    end else begin
      run_b    = run_sum_q;
      rst_b    = run_start_q;
      best_b   = best_q;
      bfirst_b = best_first_q;
      bpast_b  = best_past_q;
      peak_b   = peak_q;
      pidx_b   = peak_idx_q;
      tot_b    = total_q;
      pre_b    = pre_best_q;
      ppast_b  = pre_past_q;
      minp_b   = min_pre_q;
      minidx_b = min_idx_q;
    end

    run_sum_d    = run_sum_q;
    run_start_d  = run_start_q;
    best_d       = best_q;
    best_first_d = best_first_q;
    best_past_d  = best_past_q;
    peak_d       = peak_q;
    peak_idx_d   = peak_idx_q;
    total_d      = total_q;
    pre_best_d   = pre_best_q;
    pre_past_d   = pre_past_q;
    min_pre_d    = min_pre_q;
    min_idx_d    = min_idx_q;
    pos_d        = pos_q;
    ovf_d        = ovf_q;

    run_sum2 = run_b + x;
    tot2     = tot_b + x;

    if (pos_q >= POS_W'(MAX_LEN)) begin
      ovf_d = 1'b1;
    end else begin
      // minimum prefix before this sample, latest index on ties
      if (tot_b <= minp_b) begin
        min_pre_d = tot_b;
        min_idx_d = pos_q[IDX_W-1:0];
      end else begin
        min_pre_d = minp_b;
        min_idx_d = minidx_b;
      end
      if (run_sum2[SUM_W-1]) begin
        run_sum_d   = '0;
        run_start_d = i_nxt;
      end else begin
        run_sum_d   = run_sum2;
        run_start_d = rst_b;
      end
      if (run_sum_d > best_b) begin
        best_d       = run_sum_d;
        best_past_d  = i_nxt;
        best_first_d = run_start_d;
      end else begin
        best_d       = best_b;
        best_past_d  = bpast_b;
        best_first_d = bfirst_b;
      end
      if (peak_b < xp) begin
        peak_d     = xp;
        peak_idx_d = pos_q[IDX_W-1:0];
      end else begin
        peak_d     = peak_b;
        peak_idx_d = pidx_b;
      end
      total_d = tot2;
      if (tot2 > pre_b) begin
        pre_best_d = tot2;
        pre_past_d = i_nxt;
      end else begin
        pre_best_d = pre_b;
        pre_past_d = ppast_b;
      end
      pos_d = i_nxt;
    end

    // a zero best sum falls back to the first maximum element
    if (best_d == '0) begin
      bsum = SUM_W'(peak_d);
      bs   = POS_W'(peak_idx_d);
      be   = POS_W'(peak_idx_d) + POS_W'(1);
    end else begin
      bsum = best_d;
      bs   = best_first_d;
      be   = best_past_d;
    end

    out_data_d = {5'b0, total_d, min_idx_d, total_d - min_pre_d, pre_past_d, pre_best_d,
                  be, bs, bsum};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      sample_q  <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sum_q    <= '0;
      run_start_q  <= '0;
      best_q       <= '0;
      best_first_q <= '0;
      best_past_q  <= '0;
      peak_q       <= '0;
      peak_idx_q   <= '0;
      total_q      <= '0;
      pre_best_q   <= '0;
      pre_past_q   <= '0;
      min_pre_q    <= '0;
      min_idx_q    <= '0;
      pos_q        <= '0;
      ovf_q        <= 1'b0;
    end else if (proc) begin
      if (in_last_q) begin
        // run ends: clear for the next one
        run_sum_q    <= '0;
        run_start_q  <= '0;
        best_q       <= '0;
        best_first_q <= '0;
        best_past_q  <= '0;
        peak_q       <= '0;
        peak_idx_q   <= '0;
        total_q      <= '0;
        pre_best_q   <= '0;
        pre_past_q   <= '0;
        min_pre_q    <= '0;
        min_idx_q    <= '0;
        pos_q        <= '0;
        ovf_q        <= 1'b0;
      end else begin
        run_sum_q    <= run_sum_d;
        run_start_q  <= run_start_d;
        best_q       <= best_d;
        best_first_q <= best_first_d;
        best_past_q  <= best_past_d;
        peak_q       <= peak_d;
        peak_idx_q   <= peak_idx_d;
        total_q      <= total_d;
        pre_best_q   <= pre_best_d;
        pre_past_q   <= pre_past_d;
        min_pre_q    <= min_pre_d;
        min_idx_q    <= min_idx_d;
        pos_q        <= pos_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      out_data_q <= out_data_d;
      out_user_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire
